@@ rtl/sfae_pkg.sv @@
// Shared constants, types and reciprocal table of the frame averager.
package sfae_pkg;

    localparam int MAX_POINTS     = 1024;
    localparam int HISTORY_FRAMES = 16;

    localparam int PW       = $clog2(MAX_POINTS);
    localparam int SW       = $clog2(HISTORY_FRAMES);
    localparam int CW       = $clog2(HISTORY_FRAMES + 1);
    localparam int LW       = PW + 1;
    localparam int SMP_W    = 8;
    localparam int WORD_W   = 2 * SMP_W;
    localparam int SUM_W    = SMP_W + SW;
    localparam int GRP      = 4;
    localparam int NGRP     = HISTORY_FRAMES / GRP;
    localparam int GSUM_W   = SMP_W + $clog2(GRP);
    localparam int AVE_W    = 16;
    localparam int NUM_W    = 20;
    localparam int RECIP_W  = 25;
    localparam int RECIP_SH = 24;
    localparam int CFG_W    = 11;
    localparam int FRM_W    = 5;
    localparam int IDX_W    = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_AVERAGE_MODE,
        REG_NUM_AVERAGE,
        REG_ENVELOPE_FRAMES,
        REG_FRAME_LENGTH
    } cfg_reg_t;

    typedef struct packed {
        logic [PW-1:0]    pos;
        logic [SW-1:0]    slot;
        logic [CW-1:0]    n;
        logic [CW-1:0]    e;
        logic             mode;
        logic             fend;
        logic [SMP_W-1:0] a;
        logic [SMP_W-1:0] b;
    } stage_t;

    // ceil(2^24 / d) for d in 1..16
    function automatic logic [RECIP_W-1:0] recip(input logic [CW-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592406;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355444;
            5'd6:    r = 25'd2796203;
            5'd7:    r = 25'd2396746;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864136;
            5'd10:   r = 25'd1677722;
            5'd11:   r = 25'd1525202;
            5'd12:   r = 25'd1398102;
            5'd13:   r = 25'd1290556;
            5'd14:   r = 25'd1198373;
            5'd15:   r = 25'd1118482;
            5'd16:   r = 25'd1048576;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/sfae_in_if.sv @@
// Sample request channel: valid, ready and one two-channel point.
interface sfae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic       frame_start;
    logic       settings_changed;

    modport source (output valid, sample_a, sample_b, frame_start, settings_changed,
                    input ready);
    modport sink   (input valid, sample_a, sample_b, frame_start, settings_changed,
                    output ready);
endinterface

@@ rtl/sfae_out_if.sv @@
// Result request channel: valid, ready and averaged and envelope values of one point.
interface sfae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] average_a;
    logic [7:0] average_b;
    logic [7:0] minimum_a;
    logic [7:0] maximum_a;
    logic [7:0] minimum_b;
    logic [7:0] maximum_b;
    logic       frame_end;

    modport source (output valid, average_a, average_b, minimum_a, maximum_a,
                    minimum_b, maximum_b, frame_end, input ready);
    modport sink   (input valid, average_a, average_b, minimum_a, maximum_a,
                    minimum_b, maximum_b, frame_end, output ready);
endinterface

@@ rtl/sfae_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sfae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/sfae_ctrl.sv @@
// Configuration registers and frame, slot and point counters.
module sfae_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [sfae_pkg::IDX_W-1:0]  cfg_index,
    input  logic [sfae_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        take,
    input  logic                        frame_start,
    input  logic                        settings_changed,
    input  logic [sfae_pkg::SMP_W-1:0]  sample_a,
    input  logic [sfae_pkg::SMP_W-1:0]  sample_b,
    output sfae_pkg::stage_t            issue
);
    import sfae_pkg::*;

    logic             mode_reg;
    logic [FRM_W-1:0] num_reg;
    logic [FRM_W-1:0] env_reg;
    logic [CFG_W-1:0] len_cfg_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [LW-1:0]    len;
    logic             start;
    logic [CW-1:0]    n_lim, e_lim;

    always_comb
    begin
        if (len_cfg_reg == '0)
            len = LW'(1);
        else if (int'(len_cfg_reg) > MAX_POINTS)
            len = LW'(MAX_POINTS);
        else
            len = LW'(len_cfg_reg);

        start = frame_start || (count_reg == '0) || ((LW'(pos_reg) + LW'(1)) >= len);
        count_next = count_reg;
        slot_next  = slot_reg;
        pos_next   = pos_reg + PW'(1);
        if (start)
        begin
            if ((count_reg == '0) || (frame_start && settings_changed))
                count_next = CW'(1);
            else if (int'(count_reg) < HISTORY_FRAMES)
                count_next = count_reg + CW'(1);
            slot_next = slot_reg + SW'(1);
            pos_next  = '0;
        end

        if (num_reg == '0)
            n_lim = CW'(1);
        else if (int'(num_reg) > HISTORY_FRAMES)
            n_lim = CW'(HISTORY_FRAMES);
        else
            n_lim = CW'(num_reg);
        if (env_reg == '0)
            e_lim = CW'(1);
        else if (int'(env_reg) > HISTORY_FRAMES)
            e_lim = CW'(HISTORY_FRAMES);
        else
            e_lim = CW'(env_reg);

        issue.pos  = pos_next;
        issue.slot = slot_next;
        issue.n    = (n_lim > count_next) ? count_next : n_lim;
        issue.e    = (e_lim > count_next) ? count_next : e_lim;
        issue.mode = mode_reg;
        issue.fend = (LW'(pos_next) + LW'(1)) >= len;
        issue.a    = sample_a;
        issue.b    = sample_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            num_reg     <= FRM_W'(1);
            env_reg     <= FRM_W'(1);
            len_cfg_reg <= CFG_W'(MAX_POINTS);
            count_reg   <= '0;
            slot_reg    <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_AVERAGE_MODE:    mode_reg    <= cfg_data[0];
                    REG_NUM_AVERAGE:     num_reg     <= cfg_data[FRM_W-1:0];
                    REG_ENVELOPE_FRAMES: env_reg     <= cfg_data[FRM_W-1:0];
                    REG_FRAME_LENGTH:    len_cfg_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (take)
            begin
                count_reg <= count_next;
                slot_reg  <= slot_next;
                pos_reg   <= pos_next;
            end
        end
    end
endmodule

@@ rtl/sfae_hist.sv @@
// Frame history memory with windowed sum and min/max reduction over stored frames.
module sfae_hist (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [sfae_pkg::PW-1:0]     raddr,
    input  logic                        v1,
    input  sfae_pkg::stage_t            st1,
    output logic [sfae_pkg::SUM_W-1:0]  sum_a,
    output logic [sfae_pkg::SUM_W-1:0]  sum_b,
    output logic [sfae_pkg::SMP_W-1:0]  min_a,
    output logic [sfae_pkg::SMP_W-1:0]  max_a,
    output logic [sfae_pkg::SMP_W-1:0]  min_b,
    output logic [sfae_pkg::SMP_W-1:0]  max_b
);
    import sfae_pkg::*;

    localparam int HW = HISTORY_FRAMES * WORD_W;

    logic [HW-1:0]     rd, merged;
    logic [SMP_W-1:0]  sa [HISTORY_FRAMES];
    logic [SMP_W-1:0]  sb [HISTORY_FRAMES];
    logic [SMP_W-1:0]  mna [HISTORY_FRAMES];
    logic [SMP_W-1:0]  mxa [HISTORY_FRAMES];
    logic [SMP_W-1:0]  mnb [HISTORY_FRAMES];
    logic [SMP_W-1:0]  mxb [HISTORY_FRAMES];
    logic [GSUM_W-1:0] gsa [NGRP];
    logic [GSUM_W-1:0] gsb [NGRP];
    logic [SMP_W-1:0]  gmna [NGRP];
    logic [SMP_W-1:0]  gmxa [NGRP];
    logic [SMP_W-1:0]  gmnb [NGRP];
    logic [SMP_W-1:0]  gmxb [NGRP];
    logic [GSUM_W-1:0] gsa_reg [NGRP];
    logic [GSUM_W-1:0] gsb_reg [NGRP];
    logic [SMP_W-1:0]  gmna_reg [NGRP];
    logic [SMP_W-1:0]  gmxa_reg [NGRP];
    logic [SMP_W-1:0]  gmnb_reg [NGRP];
    logic [SMP_W-1:0]  gmxb_reg [NGRP];
    logic [SUM_W-1:0]  sum_a_next, sum_b_next, sum_a_reg, sum_b_reg;
    logic [SMP_W-1:0]  min_a_next, max_a_next, min_b_next, max_b_next;
    logic [SMP_W-1:0]  min_a_reg, max_a_reg, min_b_reg, max_b_reg;

    sfae_ram #(.WIDTH(HW), .DEPTH(MAX_POINTS)) u_mem (
        .clk   (clk),
        .we    (adv && v1),
        .waddr (st1.pos),
        .wdata (merged),
        .re    (adv),
        .raddr (raddr),
        .rdata (rd)
    );

    always_comb
    begin
        merged = rd;
        merged[int'(st1.slot) * WORD_W +: WORD_W] = {st1.b, st1.a};
    end

    always_comb
    begin : mask
        logic [SW-1:0]    age;
        logic [SMP_W-1:0] wa, wb;
        logic             in_avg, in_env;
        for (int i = 0; i < HISTORY_FRAMES; i++)
        begin
            age    = st1.slot - SW'(i);
            wa     = merged[i * WORD_W +: SMP_W];
            wb     = merged[i * WORD_W + SMP_W +: SMP_W];
            in_avg = CW'(age) < st1.n;
            in_env = CW'(age) < st1.e;
            sa[i]  = in_avg ? wa : '0;
            sb[i]  = in_avg ? wb : '0;
            mna[i] = in_env ? wa : '1;
            mxa[i] = in_env ? wa : '0;
            mnb[i] = in_env ? wb : '1;
            mxb[i] = in_env ? wb : '0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            gsa[g]  = '0;
            gsb[g]  = '0;
            gmna[g] = '1;
            gmxa[g] = '0;
            gmnb[g] = '1;
            gmxb[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                gsa[g] = gsa[g] + GSUM_W'(sa[g * GRP + j]);
                gsb[g] = gsb[g] + GSUM_W'(sb[g * GRP + j]);
                if (mna[g * GRP + j] < gmna[g]) gmna[g] = mna[g * GRP + j];
                if (mxa[g * GRP + j] > gmxa[g]) gmxa[g] = mxa[g * GRP + j];
                if (mnb[g * GRP + j] < gmnb[g]) gmnb[g] = mnb[g * GRP + j];
                if (mxb[g * GRP + j] > gmxb[g]) gmxb[g] = mxb[g * GRP + j];
            end
        end
    end

    always_comb
    begin
        sum_a_next = '0;
        sum_b_next = '0;
        min_a_next = '1;
        max_a_next = '0;
        min_b_next = '1;
        max_b_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum_a_next = sum_a_next + SUM_W'(gsa_reg[g]);
            sum_b_next = sum_b_next + SUM_W'(gsb_reg[g]);
            if (gmna_reg[g] < min_a_next) min_a_next = gmna_reg[g];
            if (gmxa_reg[g] > max_a_next) max_a_next = gmxa_reg[g];
            if (gmnb_reg[g] < min_b_next) min_b_next = gmnb_reg[g];
            if (gmxb_reg[g] > max_b_next) max_b_next = gmxb_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                gsa_reg[g]  <= gsa[g];
                gsb_reg[g]  <= gsb[g];
                gmna_reg[g] <= gmna[g];
                gmxa_reg[g] <= gmxa[g];
                gmnb_reg[g] <= gmnb[g];
                gmxb_reg[g] <= gmxb[g];
            end
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            min_a_reg <= min_a_next;
            max_a_reg <= max_a_next;
            min_b_reg <= min_b_next;
            max_b_reg <= max_b_next;
        end
    end

    assign sum_a = sum_a_reg;
    assign sum_b = sum_b_reg;
    assign min_a = min_a_reg;
    assign max_a = max_a_reg;
    assign min_b = min_b_reg;
    assign max_b = max_b_reg;
endmodule

@@ rtl/sfae_recur.sv @@
// Recursive 8.8 running average with its per-point memory.
module sfae_recur (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [sfae_pkg::PW-1:0]     raddr,
    input  logic                        v1,
    input  sfae_pkg::stage_t            st1,
    input  logic                        v3,
    input  logic [sfae_pkg::PW-1:0]     pos3,
    output logic [sfae_pkg::SMP_W-1:0]  ave_a,
    output logic [sfae_pkg::SMP_W-1:0]  ave_b
);
    import sfae_pkg::*;

    logic [2*AVE_W-1:0]         rd;
    logic [CW-1:0]              nm1;
    logic [NUM_W:0]             full_a, full_b;
    logic [NUM_W-1:0]           num_a_next, num_b_next, num_a_reg, num_b_reg;
    logic [CW-1:0]              n_reg;
    logic [RECIP_W-1:0]         r;
    logic [NUM_W+RECIP_W-1:0]   prod_a, prod_b;
    logic [AVE_W-1:0]           avq_a_reg, avq_b_reg;

    sfae_ram #(.WIDTH(2 * AVE_W), .DEPTH(MAX_POINTS)) u_mem (
        .clk   (clk),
        .we    (adv && v3),
        .waddr (pos3),
        .wdata ({avq_b_reg, avq_a_reg}),
        .re    (adv),
        .raddr (raddr),
        .rdata (rd)
    );

    always_comb
    begin
        nm1    = st1.n - CW'(1);
        full_a = (NUM_W+1)'(rd[AVE_W-1:0]) * (NUM_W+1)'(nm1)
               + (NUM_W+1)'({st1.a, 8'h00});
        full_b = (NUM_W+1)'(rd[2*AVE_W-1:AVE_W]) * (NUM_W+1)'(nm1)
               + (NUM_W+1)'({st1.b, 8'h00});
        if (st1.n <= CW'(1))
        begin
            num_a_next = NUM_W'({st1.a, 8'h00});
            num_b_next = NUM_W'({st1.b, 8'h00});
        end
        else
        begin
            num_a_next = full_a[NUM_W-1:0];
            num_b_next = full_b[NUM_W-1:0];
        end
    end

    always_comb
    begin
        r      = recip(n_reg);
        prod_a = (NUM_W+RECIP_W)'(num_a_reg) * (NUM_W+RECIP_W)'(r);
        prod_b = (NUM_W+RECIP_W)'(num_b_reg) * (NUM_W+RECIP_W)'(r);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_a_reg <= num_a_next;
            num_b_reg <= num_b_next;
            n_reg     <= st1.n;
            avq_a_reg <= prod_a[RECIP_SH +: AVE_W];
            avq_b_reg <= prod_b[RECIP_SH +: AVE_W];
        end
    end

    assign ave_a = avq_a_reg[AVE_W-1:AVE_W-SMP_W];
    assign ave_b = avq_b_reg[AVE_W-1:AVE_W-SMP_W];
endmodule

@@ rtl/scope_frame_average_envelope.sv @@
// Top level of the two-channel frame averager and min/max envelope.
// One point per clock in steady state; after its request is taken, a result passes through
// stages for the memory reads, the group reduction and the divides, and a final output
// register. Both memories are read once per point at full width, and the running average
// memory is written back from the last stage before the output register; a point whose
// position is still in flight therefore waits, so frames shorter than four points run below
// one point per clock. An output stall holds the whole pipeline. The memories need no clearing pass.
module scope_frame_average_envelope (
    input  logic                       clk,
    input  logic                       rst_n,
    sfae_in_if.sink                    samples,
    sfae_out_if.source                 results,
    input  logic                       cfg_write,
    input  logic [sfae_pkg::IDX_W-1:0] cfg_index,
    input  logic [sfae_pkg::CFG_W-1:0] cfg_data
);
    import sfae_pkg::*;

    stage_t            issue;
    stage_t            st1_reg, st2_reg, st3_reg;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              adv, hazard, take;
    logic [SUM_W-1:0]  sum_a, sum_b;
    logic [SMP_W-1:0]  min_a, max_a, min_b, max_b, rec_a, rec_b;
    logic [RECIP_W-1:0]        rk;
    logic [SUM_W+RECIP_W-1:0]  prod_a, prod_b;
    logic [SMP_W-1:0]  avg_a_reg, avg_b_reg, min_a_reg, max_a_reg, min_b_reg, max_b_reg;
    logic              fend_reg;

    assign adv    = !v4_reg || results.ready;
    assign hazard = (v1_reg && (st1_reg.pos == issue.pos))
                 || (v2_reg && (st2_reg.pos == issue.pos))
                 || (v3_reg && (st3_reg.pos == issue.pos));
    assign samples.ready = adv && !hazard;
    assign take = samples.valid && samples.ready;

    sfae_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .take             (take),
        .frame_start      (samples.frame_start),
        .settings_changed (samples.settings_changed),
        .sample_a         (samples.sample_a),
        .sample_b         (samples.sample_b),
        .issue            (issue)
    );

    sfae_hist u_hist (
        .clk   (clk),
        .adv   (adv),
        .raddr (issue.pos),
        .v1    (v1_reg),
        .st1   (st1_reg),
        .sum_a (sum_a),
        .sum_b (sum_b),
        .min_a (min_a),
        .max_a (max_a),
        .min_b (min_b),
        .max_b (max_b)
    );

    sfae_recur u_recur (
        .clk   (clk),
        .adv   (adv),
        .raddr (issue.pos),
        .v1    (v1_reg),
        .st1   (st1_reg),
        .v3    (v3_reg),
        .pos3  (st3_reg.pos),
        .ave_a (rec_a),
        .ave_b (rec_b)
    );

    always_comb
    begin
        rk     = recip(st3_reg.n);
        prod_a = (SUM_W+RECIP_W)'(sum_a) * (SUM_W+RECIP_W)'(rk);
        prod_b = (SUM_W+RECIP_W)'(sum_b) * (SUM_W+RECIP_W)'(rk);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg   <= issue;
            st2_reg   <= st1_reg;
            st3_reg   <= st2_reg;
            avg_a_reg <= st3_reg.mode ? rec_a : prod_a[RECIP_SH +: SMP_W];
            avg_b_reg <= st3_reg.mode ? rec_b : prod_b[RECIP_SH +: SMP_W];
            min_a_reg <= min_a;
            max_a_reg <= max_a;
            min_b_reg <= min_b;
            max_b_reg <= max_b;
            fend_reg  <= st3_reg.fend;
        end
    end

    assign results.valid     = v4_reg;
    assign results.average_a = avg_a_reg;
    assign results.average_b = avg_b_reg;
    assign results.minimum_a = min_a_reg;
    assign results.maximum_a = max_a_reg;
    assign results.minimum_b = min_b_reg;
    assign results.maximum_b = max_b_reg;
    assign results.frame_end = fend_reg;
endmodule

@@ rtl/sfae_checker.sv @@
// Port-level checker for the frame averager and its bind to the top level.
module sfae_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] average_a,
    input logic [7:0] min_a,
    input logic [7:0] max_a,
    input logic [7:0] min_b,
    input logic [7:0] max_b
);
    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_a))
        else $error("stalled result changed");

    // envelope ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_a <= max_a) && (min_b <= max_b))
        else $error("envelope minimum above maximum");

    // drop ready while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

    // a taken request reaches the output while out_ready stays high
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing after pipeline latency");
endmodule

bind scope_frame_average_envelope sfae_checker u_sfae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .average_a (results.average_a),
    .min_a     (results.minimum_a),
    .max_a     (results.maximum_a),
    .min_b     (results.minimum_b),
    .max_b     (results.maximum_b)
);

@@ test/testbench.sv @@
// Self-checking testbench of the two-channel frame averager and min/max envelope.
`timescale 1ns / 1ps

module testbench;
    import sfae_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [7:0] average_a;
        logic [7:0] average_b;
        logic [7:0] minimum_a;
        logic [7:0] maximum_a;
        logic [7:0] minimum_b;
        logic [7:0] maximum_b;
        logic       frame_end;
    } point_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    sfae_in_if  in_ch();
    sfae_out_if out_ch();

    scope_frame_average_envelope dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (in_ch),
        .results   (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // predicted state
    logic [15:0] history_mem [HISTORY_FRAMES*MAX_POINTS];
    logic [31:0] average_mem [MAX_POINTS];
    int unsigned frame_count;
    int unsigned slot_now;
    int unsigned position_now;
    int unsigned mode_reg;
    int unsigned num_reg;
    int unsigned env_reg;
    int unsigned length_reg;
    logic        restart_needed;

    point_result_t expected_points [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned points_sent = 0;
    int unsigned points_checked = 0;
    int unsigned frames_started = 0;
    int unsigned hold_cycles = 0;
    logic        steady = 1'b0;

    function automatic int unsigned clamp_frames(int unsigned v);
        if (v == 0) return 1;
        if (v > HISTORY_FRAMES) return HISTORY_FRAMES;
        return v;
    endfunction

    function automatic int unsigned effective_length();
        if (length_reg == 0) return 1;
        if (length_reg > MAX_POINTS) return MAX_POINTS;
        return length_reg;
    endfunction

    function automatic int unsigned recurse(int unsigned ave, int unsigned x, int unsigned n);
        if (n <= 1) return x << 8;
        return (ave * (n - 1) + (x << 8)) / n;
    endfunction

    function automatic point_result_t predict_point(logic [7:0] a, logic [7:0] b,
                                                    logic fs, logic sc);
        point_result_t r;
        int unsigned len, n, e, s, pos, ava, avb;
        int unsigned sum_a, sum_b, mn_a, mx_a, mn_b, mx_b, wa, wb;
        logic [31:0] ave;
        len = effective_length();
        sum_a = 0; sum_b = 0;
        mn_a = 255; mx_a = 0; mn_b = 255; mx_b = 0;
        if (fs || frame_count == 0 || position_now + 1 >= len) begin
            if (frame_count == 0 || (fs && sc))
                frame_count = 1;
            else if (frame_count < HISTORY_FRAMES)
                frame_count++;
            slot_now = (slot_now + 1) % HISTORY_FRAMES;
            position_now = 0;
            frames_started++;
        end
        else
        begin
            position_now++;
        end
        pos = position_now % MAX_POINTS;
        history_mem[slot_now*MAX_POINTS + pos] = {b, a};
        n = clamp_frames(num_reg);
        if (n > frame_count) n = frame_count;
        e = clamp_frames(env_reg);
        if (e > frame_count) e = frame_count;
        for (int j = 0; j < HISTORY_FRAMES; j++)
        begin
            if (j < n || j < e)
            begin
                s = (slot_now + HISTORY_FRAMES - j) % HISTORY_FRAMES;
                wa = history_mem[s*MAX_POINTS + pos][7:0];
                wb = history_mem[s*MAX_POINTS + pos][15:8];
                if (j < n)
                begin
                    sum_a += wa;
                    sum_b += wb;
                end
                if (j < e)
                begin
                    if (wa < mn_a) mn_a = wa;
                    if (wa > mx_a) mx_a = wa;
                    if (wb < mn_b) mn_b = wb;
                    if (wb > mx_b) mx_b = wb;
                end
            end
        end
        ave = (n > 1) ? average_mem[pos] : 32'd0;
        ava = recurse(ave[15:0], a, n) & 16'hffff;
        avb = recurse(ave[31:16], b, n) & 16'hffff;
        average_mem[pos] = {avb[15:0], ava[15:0]};
        if (mode_reg != 0)
        begin
            r.average_a = ava[15:8];
            r.average_b = avb[15:8];
        end
        else
        begin
            r.average_a = 8'(sum_a / n);
            r.average_b = 8'(sum_b / n);
        end
        r.minimum_a = 8'(mn_a);
        r.maximum_a = 8'(mx_a);
        r.minimum_b = 8'(mn_b);
        r.maximum_b = 8'(mx_b);
        r.frame_end = (position_now + 1 >= len);
        return r;
    endfunction

    function automatic int unsigned gap_length();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 points_checked, field, got, want);
        errors++;
    endtask

    // result checker and receiver stalls
    int unsigned stall_left = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("result with no request waiting", 1, 0);
            end
            else
            begin
                point_result_t w;
                w = expected_points.pop_front();
                if (out_ch.average_a !== w.average_a)
                    report_mismatch("average_a", out_ch.average_a, w.average_a);
                if (out_ch.average_b !== w.average_b)
                    report_mismatch("average_b", out_ch.average_b, w.average_b);
                if (out_ch.minimum_a !== w.minimum_a)
                    report_mismatch("minimum_a", out_ch.minimum_a, w.minimum_a);
                if (out_ch.maximum_a !== w.maximum_a)
                    report_mismatch("maximum_a", out_ch.maximum_a, w.maximum_a);
                if (out_ch.minimum_b !== w.minimum_b)
                    report_mismatch("minimum_b", out_ch.minimum_b, w.minimum_b);
                if (out_ch.maximum_b !== w.maximum_b)
                    report_mismatch("maximum_b", out_ch.maximum_b, w.maximum_b);
                if (out_ch.frame_end !== w.frame_end)
                    report_mismatch("frame_end", out_ch.frame_end, w.frame_end);
            end
            points_checked <= points_checked + 1;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_left <= gap_length();
            out_ch.ready <= 1'b1;
        end
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_point(logic [7:0] a, logic [7:0] b, logic fs, logic sc);
        int unsigned gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_a <= a;
        in_ch.sample_b <= b;
        in_ch.frame_start <= fs;
        in_ch.settings_changed <= sc;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_points.push_back(predict_point(a, b, fs, sc));
        points_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        case (idx)
            REG_AVERAGE_MODE:    mode_reg = value & 1;
            REG_NUM_AVERAGE:     num_reg = value & 5'h1f;
            REG_ENVELOPE_FRAMES: env_reg = value & 5'h1f;
            REG_FRAME_LENGTH:
            begin
                length_reg = value & 11'h7ff;
                restart_needed = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned mode, int unsigned num, int unsigned env,
                             int unsigned len);
        drain();
        write_reg(REG_AVERAGE_MODE, mode);
        write_reg(REG_NUM_AVERAGE, num);
        write_reg(REG_ENVELOPE_FRAMES, env);
        write_reg(REG_FRAME_LENGTH, len);
        cfg_write <= 1'b0;
    endtask

    // a frame may only follow with equal settings once the previous one is complete
    task automatic send_random_point(int unsigned start_pct);
        logic fs, sc, at_end;
        at_end = (frame_count == 0) || (position_now + 1 >= effective_length());
        fs = ($urandom_range(0, 99) < (at_end ? 50 : start_pct));
        sc = $urandom_range(0, 3) == 0;
        if (fs && !at_end) sc = 1'b1;
        if (restart_needed)
        begin
            fs = 1'b1;
            sc = 1'b1;
            restart_needed = 1'b0;
        end
        send_point(8'($urandom), 8'($urandom), fs, sc);
    endtask

    task automatic test_after_reset();
        // first point opens a frame without frame_start
        restart_needed = 1'b0;
        send_point(8'd0, 8'd255, 1'b0, 1'b0);
        send_point(8'd255, 8'd0, 1'b0, 1'b1);
        send_point(8'd128, 8'd127, 1'b0, 1'b0);
        send_point(8'd1, 8'd254, 1'b1, 1'b1);
        send_point(8'd170, 8'd85, 1'b0, 1'b0);
    endtask

    task automatic test_extremes();
        configure(0, 16, 16, 2);
        for (int f = 0; f < 18; f++)
        begin
            send_point((f % 2) ? 8'd255 : 8'd0, (f % 3) ? 8'd0 : 8'd255,
                       1'b1, f == 0);
            send_point(8'(f * 14), 8'(255 - f * 14), 1'b0, 1'b0);
        end
        configure(1, 16, 1, 1);
        for (int f = 0; f < 20; f++)
            send_point((f < 10) ? 8'd255 : 8'd0, 8'(f * 13), f == 0, f == 0);
    endtask

    task automatic test_out_of_range();
        configure(0, 0, 31, 0);
        for (int i = 0; i < 20; i++)
            send_random_point(20);
        configure(1, 17, 0, 2047);
        for (int i = 0; i < 30; i++)
            send_random_point(0);
    endtask

    task automatic test_backpressure();
        configure(0, 4, 3, 5);
        hold_cycles = 300;
        for (int i = 0; i < 60; i++)
            send_random_point(5);
    endtask

    task automatic test_random();
        int unsigned len, items;
        for (int p = 0; p < 14; p++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
            configure($urandom_range(0, 1), $urandom_range(1, 16), $urandom_range(1, 16), len);
            steady = (p % 5 == 3);
            items = 40;
            for (int i = 0; i < items; i++)
                send_random_point(($urandom_range(0, 9) == 0) ? 30 : 2);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.sample_a = '0;
        in_ch.sample_b = '0;
        in_ch.frame_start = 1'b0;
        in_ch.settings_changed = 1'b0;
        frame_count = 0;
        slot_now = 0;
        position_now = 0;
        mode_reg = 0;
        num_reg = 1;
        env_reg = 1;
        length_reg = 1024;
        restart_needed = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_extremes();
        test_out_of_range();
        test_backpressure();
        test_random();
        drain();
        $display("sent %0d points in %0d frames, checked %0d results", points_sent,
                 frames_started, points_checked);
        $display("covered both average modes, clamped registers and output back-pressure");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
